// File: rtl/core/etur_pkg.sv
package etur_pkg;

	localparam int unsigned FRAME_BITS      = 9;
	localparam int unsigned BAUD_DIV_RESET  = 26;
	localparam int unsigned FIFO_DEPTH_DEF  = 256;
	localparam int unsigned DIV_STEPS       = 33;
	localparam int unsigned CNT_W           = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] FUNC_EDGE    = 2'd0;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [1:0] FUNC_POP     = 2'd2;
	localparam logic [1:0] FUNC_NOP     = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] timestamp;
		logic        pin_level;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       data_available;
		logic       dropped;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_APPLY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic start_frame;
		logic div_start;
		logic div_step;
		logic apply;
		logic timeout;
		logic abandon;
		logic pop;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       pin_same;
		logic       awaiting;
		logic       line_level;
		logic       nonempty;
		logic       div_last;
		logic       out_free;
	} stat_t;

	// shift n copies of level in from the top, LSB-first order
	function automatic logic [7:0] shift_fill(input logic [7:0] sr, input logic [3:0] n,
		input logic level);
		logic [7:0] fill;
		logic [7:0] res;
		fill = ~(8'hFF >> n[2:0]);
		if (n >= 4'd8) begin
			res = {8{level}};
		end else begin
			res = (sr >> n[2:0]) | (level ? fill : 8'h00);
		end
		return res;
	endfunction

endpackage

// File: rtl/core/edge_timed_uart_receiver_unit.sv
// channel   signals                          direction  payload
// item      item_valid / item_ready / item   in         etur_pkg::item_t
// result    result_valid / result_ready      out        etur_pkg::result_t
// cfg       cfg_valid / cfg_ready / cfg_data in         ticks per bit, 16 bits
//
// An edge that decodes bits goes through the EVAL, DIV, APPLY and FIN states: the
// restoring divider runs one quotient bit per cycle over a 33-bit dividend. Other
// items go from EVAL to FIN. One item is in flight at a time; a finished
// result sits in the output register, so a new item can be taken while it
// waits. The FIFO store needs no clearing pass after reset. cfg is always ready.
module edge_timed_uart_receiver_unit #(
	parameter int unsigned FIFO_DEPTH = etur_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  etur_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_ready,
	output etur_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	etur_pkg::cmd_t  cmd;
	etur_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	etur_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	etur_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

// File: rtl/core/etur_ctrl.sv
module etur_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  etur_pkg::stat_t   stat,
	output etur_pkg::cmd_t    cmd
);

	etur_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etur_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			etur_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_nx = etur_pkg::ST_EVAL;
				end
			end
			etur_pkg::ST_EVAL: begin
				state_nx = etur_pkg::ST_FIN;
				case (stat.func)
					etur_pkg::FUNC_EDGE: begin
						if (!stat.pin_same) begin
							if (stat.awaiting) begin
								cmd.start_frame = 1'b1;
							end else begin
								cmd.div_start = 1'b1;
								state_nx      = etur_pkg::ST_DIV;
							end
						end
					end
					etur_pkg::FUNC_TIMEOUT: begin
						if (!stat.awaiting) begin
							if (stat.line_level) begin
								cmd.timeout = 1'b1;
							end else begin
								cmd.abandon = 1'b1;
							end
						end
					end
					etur_pkg::FUNC_POP: begin
						cmd.pop = stat.nonempty;
					end
					default: begin
					end
				endcase
			end
			etur_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = etur_pkg::ST_APPLY;
				end
			end
			etur_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nx  = etur_pkg::ST_FIN;
			end
			etur_pkg::ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = etur_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = etur_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/etur_dp.sv
module etur_dp #(
	parameter int unsigned FIFO_DEPTH = etur_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  etur_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_ready,
	output etur_pkg::result_t  result,
	input  etur_pkg::cmd_t     cmd,
	output etur_pkg::stat_t    stat
);

	localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);

	etur_pkg::item_t         item_q;
	etur_pkg::result_t       result_q;
	logic                    result_valid_q;
	logic [15:0]             baud_div_q;
	logic                    line_q;
	logic                    await_q;
	logic [3:0]              bits_q;
	logic [7:0]              shift_q;
	logic [31:0]             last_ts_q;
	logic [IDX_W-1:0]        wr_q;
	logic [IDX_W-1:0]        rd_q;
	logic [7:0]              mem [FIFO_DEPTH];
	logic [7:0]              rd_data_q;
	logic                    valid_q;
	logic                    drop_q;
	logic [32:0]             quo_q;
	logic [15:0]             rem_q;
	logic [etur_pkg::CNT_W-1:0] cnt_q;

	logic [15:0]      bt;
	logic [31:0]      elapsed;
	logic [32:0]      num;
	logic [16:0]      trial;
	logic [16:0]      diff;
	logic             ge;
	logic             clamp;
	logic [3:0]       nbits;
	logic [3:0]       bits_nx;
	logic [7:0]       applied;
	logic [7:0]       filled;
	logic             push;
	logic [7:0]       push_byte;
	logic [IDX_W-1:0] wr_nx;
	logic [IDX_W-1:0] rd_nx;
	logic             full;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign bt      = (baud_div_q == 16'd0) ? 16'd1 : baud_div_q;
	assign elapsed = item_q.timestamp - last_ts_q;
	assign num     = {1'b0, elapsed} + {18'd0, bt[15:1]};

	assign trial = {rem_q, quo_q[32]};
	assign diff  = trial - {1'b0, bt};
	assign ge    = (trial >= {1'b0, bt});

	assign clamp   = (|quo_q[32:4]) || (quo_q[3:0] > bits_q);
	assign nbits   = clamp ? bits_q : quo_q[3:0];
	assign bits_nx = bits_q - nbits;
	assign applied = etur_pkg::shift_fill(shift_q, nbits, line_q);
	assign filled  = etur_pkg::shift_fill(shift_q, bits_q, 1'b1);

	assign push      = (cmd.apply && (bits_nx == 4'd0)) || cmd.timeout;
	assign push_byte = cmd.timeout ? filled : applied;
	assign wr_nx     = next_idx(wr_q);
	assign rd_nx     = next_idx(rd_q);
	assign full      = (wr_nx == rd_q);

	always_comb begin
		stat            = '0;
		stat.func       = item_q.func;
		stat.pin_same   = (item_q.pin_level == line_q);
		stat.awaiting   = await_q;
		stat.line_level = line_q;
		stat.nonempty   = (wr_q != rd_q);
		stat.div_last   = (cnt_q == etur_pkg::CNT_W'(1));
		stat.out_free   = !result_valid_q || result_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_div_q     <= 16'(etur_pkg::BAUD_DIV_RESET);
			line_q         <= 1'b1;
			await_q        <= 1'b1;
			bits_q         <= 4'(etur_pkg::FRAME_BITS);
			shift_q        <= 8'h00;
			wr_q           <= '0;
			rd_q           <= '0;
			result_valid_q <= 1'b0;
			cnt_q          <= '0;
		end else begin
			if (cfg_valid) begin
				baud_div_q <= cfg_data;
			end
			if (cmd.start_frame) begin
				line_q  <= 1'b0;
				await_q <= 1'b0;
				bits_q  <= 4'(etur_pkg::FRAME_BITS);
				shift_q <= 8'h00;
			end
			if (cmd.div_start) begin
				cnt_q <= etur_pkg::CNT_W'(etur_pkg::DIV_STEPS);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.apply) begin
				shift_q <= applied;
				bits_q  <= bits_nx;
				if (bits_nx == 4'd0) begin
					await_q <= 1'b1;
					line_q  <= 1'b1;
				end else begin
					line_q  <= ~line_q;
				end
			end
			if (cmd.timeout) begin
				shift_q <= filled;
				bits_q  <= 4'd0;
			end
			if (cmd.timeout || cmd.abandon) begin
				await_q <= 1'b1;
				line_q  <= 1'b1;
			end
			if (push && !full) begin
				wr_q <= wr_nx;
			end
			if (cmd.pop) begin
				rd_q <= rd_nx;
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			valid_q <= 1'b0;
			drop_q  <= 1'b0;
		end
		if (cmd.start_frame || cmd.div_start) begin
			last_ts_q <= item_q.timestamp;
		end
		if (cmd.div_start) begin
			rem_q <= 16'd0;
			// num of zero gives a count of zero
			quo_q <= (num == 33'd0) ? 33'd0 : num - 33'd1;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[31:0], ge};
		end
		if (push) begin
			drop_q <= full;
			if (!full) begin
				mem[wr_q] <= push_byte;
			end
		end
		if (cmd.pop) begin
			rd_data_q <= mem[rd_q];
			valid_q   <= 1'b1;
		end
		if (cmd.finish) begin
			result_q.data           <= valid_q ? rd_data_q : 8'h00;
			result_q.data_valid     <= valid_q;
			result_q.data_available <= (wr_q != rd_q);
			result_q.dropped        <= drop_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
